// ===== hw/rtl/second_order_iir_highpass_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the second-order IIR high-pass block
// Thin wrappers around concurrent assertions, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef SECOND_ORDER_IIR_HIGHPASS_ASSERT_SVH
`define SECOND_ORDER_IIR_HIGHPASS_ASSERT_SVH

// Same-cycle implication.
`define SOIH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("soih assertion failed");

// Next-cycle implication.
`define SOIH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("soih assertion failed");

`endif

// ===== hw/rtl/soih_pkg.sv =====
// ---------------------------------------------------------------------------
// soih_pkg
// Widths, register indexes, reset values and fixed-point helpers.
// ---------------------------------------------------------------------------
package soih_pkg;

  localparam int SAMPLE_W   = 32;  // Q8.24
  localparam int COEF_W     = 32;  // Q4.28
  localparam int HIST_W     = 40;  // Q16.24
  localparam int PROD_W     = HIST_W + COEF_W;   // full product
  localparam int FRAC_SHIFT = 28;
  localparam int TERM_W     = PROD_W - FRAC_SHIFT; // rounded product
  localparam int SUM_W      = TERM_W + 2;          // sum of three terms
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ENABLE     = 3'd0,
    REG_COEF_FEEDBACK_ONE = 3'd1,
    REG_COEF_FEEDBACK_TWO = 3'd2,
    REG_COEF_FORWARD_ONE  = 3'd3,
    REG_COEF_FORWARD_TWO  = 3'd4
  } soih_reg_t;

  localparam logic               RST_FILTER_ENABLE     = 1'b1;
  localparam logic signed [31:0] RST_COEF_FEEDBACK_ONE = 32'sd515798729;
  localparam logic signed [31:0] RST_COEF_FEEDBACK_TWO = -32'sd248157842;
  localparam logic signed [31:0] RST_COEF_FORWARD_ONE  = -32'sd526533463;
  localparam logic signed [31:0] RST_COEF_FORWARD_TWO  = 32'sd258098007;

  localparam logic signed [PROD_W-1:0] RND_POS = PROD_W'(64'd1 << (FRAC_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] RND_NEG = PROD_W'((64'd1 << (FRAC_SHIFT - 1)) - 64'd1);

  // h*c / 2^28, rounded to nearest with ties away from zero.
  function automatic logic signed [TERM_W-1:0] mul_q28(
    input logic signed [HIST_W-1:0] h,
    input logic signed [COEF_W-1:0] c
  );
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] s;
    p = PROD_W'(h) * PROD_W'(c);
    s = p + (p[PROD_W-1] ? RND_NEG : RND_POS);
    return s[PROD_W-1:FRAC_SHIFT];
  endfunction

  // True when the sum does not fit in the signed history width.
  function automatic logic ovf_hist(input logic signed [SUM_W-1:0] v);
    return !((&v[SUM_W-1:HIST_W-1]) || !(|v[SUM_W-1:HIST_W-1]));
  endfunction

  function automatic logic ovf_out(input logic signed [SUM_W-1:0] v);
    return !((&v[SUM_W-1:SAMPLE_W-1]) || !(|v[SUM_W-1:SAMPLE_W-1]));
  endfunction

  function automatic logic signed [HIST_W-1:0] clip_hist(input logic signed [SUM_W-1:0] v);
    logic signed [HIST_W-1:0] r;
    r = v[HIST_W-1:0];
    if (ovf_hist(v)) begin
      r = v[SUM_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip_out(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    r = v[SAMPLE_W-1:0];
    if (ovf_out(v)) begin
      r = v[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/second_order_iir_highpass.sv =====
// ---------------------------------------------------------------------------
// second_order_iir_highpass
// Fixed-point second-order recursive high-pass section, one sample a cycle while out_tready allows.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: in_tdata carries a signed Q8.24 sample, in_tuser flags the
//   first sample of a channel, which clears both history values before the
//   sample is filtered. Output stream: out_tdata is the saturated Q8.24
//   result, out_tuser is set when the history or the output was clipped.
//   Configuration: cfg_we/cfg_index/cfg_wdata write the enable bit and the
//   four Q4.28 coefficients; write only while no transaction is in flight.
// Path: an accepted sample passes the input register, then the result
//   register, before out_tvalid rises; a low out_tready holds it there.
// Throughput: one sample per cycle while out_tready allows. The limit is the
//   combinational path from the history registers: four 40x32 products,
//   two three-term adds and two saturations.
// Reset: valids drop, history clears, registers return to their defaults.
// Stall: with out_tready low the result holds and one more sample sits in the
//   input register; in_tready falls only when both are occupied.
// ---------------------------------------------------------------------------
`include "second_order_iir_highpass_assert.svh"

module second_order_iir_highpass (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [soih_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [soih_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_in
  input  logic        in_tuser,   // [0] channel_start
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sample_out
  output logic        out_tuser   // [0] saturated
);

  localparam int HW = soih_pkg::HIST_W;
  localparam int SW = soih_pkg::SUM_W;
  localparam int TW = soih_pkg::TERM_W;

  // configuration registers
  logic                     filter_enable_r;
  logic signed [31:0]       coef_fb1_r, coef_fb2_r, coef_fw1_r, coef_fw2_r;

  // input stage
  logic                     s1_valid_r;
  logic signed [31:0]       s1_sample_r;
  logic                     s1_start_r;

  // result stage
  logic                     out_valid_r;
  logic [31:0]              out_sample_r;
  logic                     out_sat_r;

  // filter history
  logic signed [HW-1:0]     hist_recent_r, hist_recent_nxt;
  logic signed [HW-1:0]     hist_older_r, hist_older_nxt;

  logic                     s1_load, out_load;
  logic signed [HW-1:0]     h1, h2;
  logic signed [TW-1:0]     p_fb1, p_fb2, p_fw1, p_fw2;
  logic signed [SW-1:0]     w_sum, y_sum;
  logic signed [HW-1:0]     w_sat;
  logic signed [31:0]       y_sat;
  logic                     sat_hit;
  logic [31:0]              res_sample;
  logic                     res_sat;

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign s1_load   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_sat_r;

  // ---- datapath ----
  assign h1 = s1_start_r ? '0 : hist_recent_r;
  assign h2 = s1_start_r ? '0 : hist_older_r;

  assign p_fb1 = soih_pkg::mul_q28(h1, coef_fb1_r);
  assign p_fb2 = soih_pkg::mul_q28(h2, coef_fb2_r);
  assign p_fw1 = soih_pkg::mul_q28(h1, coef_fw1_r);
  assign p_fw2 = soih_pkg::mul_q28(h2, coef_fw2_r);

  assign w_sum = SW'(p_fb1) + SW'(p_fb2) + SW'(s1_sample_r);
  assign w_sat = soih_pkg::clip_hist(w_sum);
  assign y_sum = SW'(w_sat) + SW'(p_fw1) + SW'(p_fw2);
  assign y_sat = soih_pkg::clip_out(y_sum);
  assign sat_hit = soih_pkg::ovf_hist(w_sum) || soih_pkg::ovf_out(y_sum);

  always_comb begin
    if (filter_enable_r) begin
      res_sample      = y_sat;
      res_sat         = sat_hit;
      hist_recent_nxt = w_sat;
      hist_older_nxt  = h1;
    end else begin
      // bypass: history only follows the channel-start clear
      res_sample      = s1_sample_r;
      res_sat         = 1'b0;
      hist_recent_nxt = h1;
      hist_older_nxt  = h2;
    end
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_enable_r <= soih_pkg::RST_FILTER_ENABLE;
      coef_fb1_r      <= soih_pkg::RST_COEF_FEEDBACK_ONE;
      coef_fb2_r      <= soih_pkg::RST_COEF_FEEDBACK_TWO;
      coef_fw1_r      <= soih_pkg::RST_COEF_FORWARD_ONE;
      coef_fw2_r      <= soih_pkg::RST_COEF_FORWARD_TWO;
    end else if (cfg_we) begin
      case (soih_pkg::soih_reg_t'(cfg_index))
        soih_pkg::REG_FILTER_ENABLE:     filter_enable_r <= cfg_wdata[0];
        soih_pkg::REG_COEF_FEEDBACK_ONE: coef_fb1_r      <= cfg_wdata;
        soih_pkg::REG_COEF_FEEDBACK_TWO: coef_fb2_r      <= cfg_wdata;
        soih_pkg::REG_COEF_FORWARD_ONE:  coef_fw1_r      <= cfg_wdata;
        soih_pkg::REG_COEF_FORWARD_TWO:  coef_fw2_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- control and history ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      hist_recent_r <= '0;
      hist_older_r  <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r   <= 1'b1;
        hist_recent_r <= hist_recent_nxt;
        hist_older_r  <= hist_older_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_sample_r <= in_tdata;
      s1_start_r  <= in_tuser;
    end
    if (out_load) begin
      out_sample_r <= res_sample;
      out_sat_r    <= res_sat;
    end
  end

  // ---- assertions ----
  `SOIH_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n,
    !in_tready, s1_valid_r && out_valid_r && !out_tready)
  `SOIH_ASSERT_IMPL(a_bypass_no_sat, clk, rst_n,
    out_load && !filter_enable_r, !res_sat)
  `SOIH_ASSERT_NEXT(a_start_bypass_clears, clk, rst_n,
    out_load && s1_start_r && !filter_enable_r,
    hist_recent_r == '0 && hist_older_r == '0)
  `SOIH_ASSERT_IMPL(a_out_from_stage, clk, rst_n,
    $rose(out_valid_r), $past(s1_valid_r))

endmodule

// ===== tb/sv/soih_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR high-pass stream checker
// Tracks configuration writes and input transactions, predicts each filtered
// sample with its own copy of the coefficients and history, and compares the
// prediction field by field with the oldest pending output transaction.
// ----------------------------------------------------------------------------
module soih_stream_checker
  import soih_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [31:0] sample_in
  input  logic                  in_tuser,   // [0] channel_start
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,  // [31:0] sample_out
  input  logic                  out_tuser,  // [0] saturated
  output int                    mismatches,
  output int                    outstanding
);

  localparam longint HIST_TOP = (longint'(1) <<< (HIST_W - 1)) - 1;
  localparam longint HIST_BOT = -(longint'(1) <<< (HIST_W - 1));
  localparam longint OUT_TOP  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint OUT_BOT  = -(longint'(1) <<< (SAMPLE_W - 1));

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                clipped;
  } filtered_t;

  filtered_t                filtered_q[$];
  logic                     enabled;
  logic signed [COEF_W-1:0] fb1, fb2, fw1, fw2;
  logic signed [HIST_W-1:0] h_recent, h_older;

  // Coefficient times history, scaled down by 2^28 and rounded on the
  // magnitude so that ties go away from zero.
  function automatic longint round_q28(input logic signed [HIST_W-1:0] h,
                                       input logic signed [COEF_W-1:0] c);
    logic [HIST_W:0]          mag_h;
    logic [COEF_W:0]          mag_c;
    logic [HIST_W+COEF_W+1:0] prod;
    longint                   q;
    mag_h = h[HIST_W-1] ? -{h[HIST_W-1], h} : {h[HIST_W-1], h};
    mag_c = c[COEF_W-1] ? -{c[COEF_W-1], c} : {c[COEF_W-1], c};
    prod  = mag_h * mag_c;
    prod  = prod + (1 << (FRAC_SHIFT - 1));
    q     = longint'(prod >> FRAC_SHIFT);
    return (h[HIST_W-1] ^ c[COEF_W-1]) ? -q : q;
  endfunction

  function automatic filtered_t filter_sample(input logic [SAMPLE_W-1:0] x_bits,
                                              input logic restart);
    longint    x, w, y;
    filtered_t r;
    x         = longint'($signed(x_bits));
    r.clipped = 1'b0;
    if (restart) begin
      h_recent = '0;
      h_older  = '0;
    end
    if (!enabled) begin
      r.sample = x_bits;
      return r;
    end
    w = round_q28(h_recent, fb1) + round_q28(h_older, fb2) + x;
    if (w > HIST_TOP) begin
      w = HIST_TOP;
      r.clipped = 1'b1;
    end else if (w < HIST_BOT) begin
      w = HIST_BOT;
      r.clipped = 1'b1;
    end
    y = w + round_q28(h_recent, fw1) + round_q28(h_older, fw2);
    if (y > OUT_TOP) begin
      y = OUT_TOP;
      r.clipped = 1'b1;
    end else if (y < OUT_BOT) begin
      y = OUT_BOT;
      r.clipped = 1'b1;
    end
    h_older  = h_recent;
    h_recent = w[HIST_W-1:0];
    r.sample = y[SAMPLE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    filtered_t want;
    if (!rst_n) begin
      enabled    = RST_FILTER_ENABLE;
      fb1        = RST_COEF_FEEDBACK_ONE;
      fb2        = RST_COEF_FEEDBACK_TWO;
      fw1        = RST_COEF_FORWARD_ONE;
      fw2        = RST_COEF_FORWARD_TWO;
      h_recent   = '0;
      h_older    = '0;
      mismatches = 0;
      filtered_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FILTER_ENABLE:     enabled = cfg_wdata[0];
          REG_COEF_FEEDBACK_ONE: fb1 = cfg_wdata[COEF_W-1:0];
          REG_COEF_FEEDBACK_TWO: fb2 = cfg_wdata[COEF_W-1:0];
          REG_COEF_FORWARD_ONE:  fw1 = cfg_wdata[COEF_W-1:0];
          REG_COEF_FORWARD_TWO:  fw2 = cfg_wdata[COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        filtered_q.push_back(filter_sample(in_tdata, in_tuser));
      end
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction: expected none, actual sample %h saturated %b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = filtered_q.pop_front();
          if (out_tdata !== want.sample) begin
            mismatches++;
            $display("%0t: sample_out mismatch: expected %h, actual %h",
                     $time, want.sample, out_tdata);
          end
          if (out_tuser !== want.clipped) begin
            mismatches++;
            $display("%0t: saturated mismatch: expected %b, actual %b",
                     $time, want.clipped, out_tuser);
          end
        end
      end
    end
    outstanding <= filtered_q.size();
  end

endmodule

// ===== tb/sv/tb_second_order_iir_highpass.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-order IIR high-pass testbench
// Streams directed corner samples and then random channel runs through the
// filter under a series of coefficient settings, with random gaps on both
// sides; the checker predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module tb_second_order_iir_highpass;
  import soih_pkg::*;

  localparam int IDLE_PCT    = 31;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 180;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  out_tuser;
  logic                  steady = 1'b0;   // no idling on either side while set
  int                    mismatches;
  int                    outstanding;
  int                    quiet = 0;

  always #5 clk = ~clk;

  second_order_iir_highpass DUT (.*);

  soih_stream_checker u_checker (.*);

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: cycles in a row with no transaction and no register write.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] corner_word(input int k);
    case (k)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // style 0: near the nominal value, 1: anything, 2: corner values
  function automatic logic [31:0] pick_coef(input int style, input logic [31:0] nominal);
    int off;
    off = int'($urandom_range(2097151)) - 1048576;
    case (style)
      0:       return nominal + off;
      1:       return $urandom;
      default: return corner_word($urandom_range(4));
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    int          sel;
    logic [31:0] raw;
    sel = $urandom_range(99);
    raw = $urandom;
    if (sel < 8) return corner_word($urandom_range(4));
    if (sel < 30) return raw;
    return $signed(raw) >>> $urandom_range(24, 4);
  endfunction

  task automatic send_sample(input logic [31:0] sample, input logic restart);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // A channel opens with a random full-range sample; some runs are broken: no opening
  // mark, or a stray mark part-way through.
  task automatic send_channel(input int len);
    logic broken;
    broken = $urandom_range(99) < 15;
    for (int i = 0; i < len; i++) begin
      if (i == 0) send_sample($urandom, !broken);
      else send_sample(pick_sample(), $urandom_range(99) < 2);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_filter(input logic en, input logic [31:0] b1, input logic [31:0] b2,
                                input logic [31:0] a1, input logic [31:0] r1);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FILTER_ENABLE;
    cfg_wdata <= {31'd0, en};
    @(posedge clk);
    cfg_index <= REG_COEF_FEEDBACK_ONE;
    cfg_wdata <= b1;
    @(posedge clk);
    cfg_index <= REG_COEF_FEEDBACK_TWO;
    cfg_wdata <= b2;
    @(posedge clk);
    cfg_index <= REG_COEF_FORWARD_ONE;
    cfg_wdata <= a1;
    @(posedge clk);
    cfg_index <= REG_COEF_FORWARD_TWO;
    cfg_wdata <= r1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int sent;
    int style;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_FILTER_ENABLE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: held full-scale positive and negative inputs, then small values with channel marks
    send_sample(corner_word(0), 1'b1);
    repeat (4) send_sample(corner_word(0), 1'b0);
    repeat (3) send_sample(corner_word(1), 1'b0);
    send_sample(corner_word(2), 1'b1);
    send_sample(corner_word(3), 1'b0);
    send_sample(corner_word(4), 1'b0);
    send_sample(32'h0100_0000, 1'b1);
    repeat (3) send_sample(corner_word(2), 1'b0);

    wait_idle();
    program_filter(1'b1, corner_word(0), corner_word(0), corner_word(0), corner_word(0));
    send_sample(corner_word(0), 1'b1);
    send_sample(corner_word(0), 1'b0);
    send_sample(corner_word(1), 1'b0);
    send_sample(corner_word(3), 1'b0);

    wait_idle();
    program_filter(1'b1, corner_word(1), corner_word(1), corner_word(1), corner_word(1));
    send_sample(corner_word(1), 1'b1);
    send_sample(corner_word(1), 1'b0);
    send_sample(corner_word(0), 1'b0);
    send_sample(corner_word(4), 1'b0);

    // bypass, with a channel mark still clearing the history
    wait_idle();
    program_filter(1'b0, RST_COEF_FEEDBACK_ONE, RST_COEF_FEEDBACK_TWO,
                   RST_COEF_FORWARD_ONE, RST_COEF_FORWARD_TWO);
    send_sample(corner_word(0), 1'b1);
    send_sample(corner_word(1), 1'b0);
    send_sample(corner_word(3), 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      style = p % 3;
      program_filter(!(p == 3 || p == 7),
                     pick_coef(style, RST_COEF_FEEDBACK_ONE),
                     pick_coef(style, RST_COEF_FEEDBACK_TWO),
                     pick_coef(style, RST_COEF_FORWARD_ONE),
                     pick_coef(style, RST_COEF_FORWARD_TWO));
      steady = (p == 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        int len;
        len = $urandom_range(60, 1);
        send_channel(len);
        sent += len;
      end
    end
    steady = 1'b0;

    wait_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
